// File: rtl/core/signed_radix_to_ascii_core_defines.svh
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_core_defines
// assertion macros used by the core's top rtl file
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_TO_ASCII_CORE_DEFINES_SVH
`define SIGNED_RADIX_TO_ASCII_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define SRA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sra assertion failed");

// consequent must hold in the cycle after the antecedent
`define SRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sra assertion failed");

`else

`define SRA_ASSERT(lbl, clk, rstn, prop)
`define SRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// shared widths, register indexes, result structs and alphabet helpers
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int NUM_W         = 32;
  localparam int RADIX_W       = 5;
  localparam int SYM_W         = 8;
  localparam int SYM_CNT       = 16;
  localparam int BANK_W        = SYM_W * SYM_CNT;
  localparam int SYM_IDX_W     = 4;
  localparam int GLYPH_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int MAX_DIGITS    = 32;
  localparam int MAX_RADIX_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI = 2'd2;

  localparam logic [SYM_W-1:0] CH_LOW   = 8'd33;
  localparam logic [SYM_W-1:0] CH_HIGH  = 8'd126;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

  localparam int NUM_FORBID = 8;
  // + - * / % = , .
  localparam logic [SYM_W-1:0] FORBID [NUM_FORBID] = '{
    8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h2C, 8'h2E
  };

  typedef struct packed {
    logic done;
    logic ok;
  } chk_res_t;

  typedef struct packed {
    logic               done;
    logic [NUM_W-1:0]   quo;
    logic [RADIX_W-1:0] rem;
  } div_res_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [BANK_W-1:0] bank,
                                               input logic [SYM_IDX_W-1:0] k);
    return bank[{k, 3'b000} +: SYM_W];
  endfunction

  function automatic logic sym_forbidden(input logic [SYM_W-1:0] c);
    logic bad;
    bad = (c < CH_LOW) || (c > CH_HIGH);
    for (int f = 0; f < NUM_FORBID; f++) begin
      if (c == FORBID[f]) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

// File: rtl/core/signed_radix_to_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_core: signed integer to text in a configured radix
// output: characters, sign first, follow one a cycle while out_stall is low
// throughput: one item at a time; in_stall is high until the item is rejected or its last character is registered
// reset: alphabet registers clear to zero, so items give no characters
// ----------------------------------------------------------------------------
`include "signed_radix_to_ascii_core_defines.svh"

module signed_radix_to_ascii_core #(
  parameter int MAX_RADIX = sra_pkg::MAX_RADIX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sra_pkg::NUM_W-1:0]   in_number,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sra_pkg::GLYPH_W-1:0]        out_glyph,
  output logic                               out_final_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sra_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DIG_W = $clog2(MAX_RADIX);
  localparam int CNT_W = $clog2(sra_pkg::MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                             state_r, state_nxt;
  logic [sra_pkg::RADIX_W-1:0]        radix_r;
  logic [sra_pkg::CFG_DATA_W-1:0]     sym_lo_r;
  logic [sra_pkg::CFG_DATA_W-1:0]     sym_hi_r;
  logic [sra_pkg::BANK_W-1:0]         bank;

  logic                               neg_r, neg_nxt;
  logic [sra_pkg::NUM_W-1:0]          mag_r, mag_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic                               div_go_r, div_go_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [sra_pkg::GLYPH_W-1:0]        out_glyph_r, out_glyph_nxt;
  logic                               out_final_res_r, out_final_res_nxt;

  logic                               in_take;
  logic                               slot_free;
  logic                               push;
  logic                               pop;
  logic [DIG_W-1:0]                   stk_top;
  logic [sra_pkg::SYM_W-1:0]          top_sym;
  sra_pkg::chk_res_t                  chk_res;
  sra_pkg::div_res_t                  div_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= '0;
      sym_lo_r <= '0;
      sym_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sra_pkg::CFG_RADIX:  radix_r  <= cfg_data[sra_pkg::RADIX_W-1:0];
        sra_pkg::CFG_SYM_LO: sym_lo_r <= cfg_data;
        sra_pkg::CFG_SYM_HI: sym_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign bank      = {sym_hi_r, sym_lo_r};

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign push      = (state_r == S_DIV) && div_res.done;
  assign pop       = (state_r == S_EMIT) && slot_free;
  assign top_sym   = sra_pkg::sym_at(bank, sra_pkg::SYM_IDX_W'(stk_top));

  sra_chk #(
    .MAX_RADIX (MAX_RADIX)
  ) u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .radix (radix_r),
    .bank  (bank),
    .res   (chk_res)
  );

  sra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (mag_r),
    .divisor  (radix_r),
    .res      (div_res)
  );

  sra_stack #(
    .DEPTH (sra_pkg::MAX_DIGITS),
    .W     (DIG_W)
  ) u_stack (
    .clk  (clk),
    .push (push),
    .pop  (pop),
    .din  (DIG_W'(div_res.rem)),
    .dout (stk_top)
  );

  always_comb begin
    state_nxt         = state_r;
    neg_nxt           = neg_r;
    mag_nxt           = mag_r;
    cnt_nxt           = cnt_r;
    div_go_nxt        = 1'b0;
    out_valid_nxt     = out_valid_r;
    out_glyph_nxt     = out_glyph_r;
    out_final_res_nxt = out_final_res_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          neg_nxt   = in_number[sra_pkg::NUM_W-1];
          // two's complement negate also gives the minimum integer's magnitude
          mag_nxt   = in_number[sra_pkg::NUM_W-1] ? (~in_number + 1'b1) : in_number;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_res.done) begin
          if (chk_res.ok) begin
            div_go_nxt = 1'b1;
            state_nxt  = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          cnt_nxt = cnt_r + 1'b1;
          mag_nxt = div_res.quo;
          if (div_res.quo == '0) begin
            state_nxt = neg_r ? S_SIGN : S_EMIT;
          end else begin
            div_go_nxt = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_glyph_nxt     = sra_pkg::CH_MINUS[sra_pkg::GLYPH_W-1:0];
          out_final_res_nxt = 1'b0;
          state_nxt         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_glyph_nxt     = top_sym[sra_pkg::GLYPH_W-1:0];
          out_final_res_nxt = (cnt_r == CNT_W'(1));
          cnt_nxt           = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      div_go_r    <= div_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r           <= neg_nxt;
    mag_r           <= mag_nxt;
    out_glyph_r     <= out_glyph_nxt;
    out_final_res_r <= out_final_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_glyph     = out_glyph_r;
  assign out_final_res = out_final_res_r;

  `SRA_ASSERT(a_glyph_printable, clk, rst_n, !out_valid_r || (out_glyph_r >= 7'd33 && out_glyph_r <= 7'd126))
  `SRA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, in_stall)
  `SRA_ASSERT(a_stack_room, clk, rst_n, !push || (cnt_r < CNT_W'(sra_pkg::MAX_DIGITS)))
  `SRA_ASSERT(a_emit_has_digit, clk, rst_n, (state_r != S_EMIT) || (cnt_r != '0))
  `SRA_ASSERT_NEXT(a_last_marked, clk, rst_n, pop && (cnt_r == CNT_W'(1)), out_valid_r && out_final_res_r)

endmodule

// File: rtl/core/sra_chk.sv
// ----------------------------------------------------------------------------
// sra_chk
// alphabet checker: radix range, then one symbol per cycle against all symbols in use and the forbidden set
// ----------------------------------------------------------------------------
module sra_chk #(
  parameter int MAX_RADIX = sra_pkg::MAX_RADIX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sra_pkg::RADIX_W-1:0]      radix,
  input  logic [sra_pkg::BANK_W-1:0]       bank,
  output sra_pkg::chk_res_t                res
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic                            ok_r, ok_nxt;
  logic [sra_pkg::SYM_IDX_W-1:0]   idx_r, idx_nxt;
  logic [sra_pkg::SYM_W-1:0]       cur;
  logic                            dup;
  logic                            bad;
  logic                            range_bad;

  always_comb begin
    range_bad = (radix < 5'd2) || (32'(radix) > sra_pkg::SYM_CNT) ||
                (32'(radix) > MAX_RADIX);
    cur = sra_pkg::sym_at(bank, idx_r);
    dup = 1'b0;
    // compare the current symbol with every other symbol in use
    for (int j = 0; j < sra_pkg::SYM_CNT; j++) begin
      if ((5'(j) < radix) && (4'(j) != idx_r) &&
          (sra_pkg::sym_at(bank, 4'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
    bad = dup || sra_pkg::sym_forbidden(cur);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ok_nxt   = ok_r;
    idx_nxt  = idx_r;
    if (start) begin
      if (range_bad) begin
        done_nxt = 1'b1;
        ok_nxt   = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        idx_nxt  = '0;
      end
    end else if (busy_r) begin
      if (bad) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        ok_nxt   = 1'b0;
      end else if (idx_r == 4'(radix - 5'd1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        ok_nxt   = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ok_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ok_r   <= ok_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign res.done = done_r;
  assign res.ok   = ok_r;

endmodule

// File: rtl/core/sra_div.sv
// ----------------------------------------------------------------------------
// sra_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sra_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sra_pkg::NUM_W-1:0]      dividend,
  input  logic [sra_pkg::RADIX_W-1:0]    divisor,
  output sra_pkg::div_res_t              res
);

  localparam int STEP_W = $clog2(sra_pkg::NUM_W);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [STEP_W-1:0]              cnt_r, cnt_nxt;
  logic [sra_pkg::NUM_W-1:0]      q_r, q_nxt;
  logic [sra_pkg::RADIX_W-1:0]    rem_r, rem_nxt;
  logic [sra_pkg::RADIX_W:0]      trial;
  logic                           ge;

  always_comb begin
    trial = {rem_r, q_r[sra_pkg::NUM_W-1]};
    ge    = trial >= {1'b0, divisor};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[sra_pkg::NUM_W-2:0], ge};
      rem_nxt = ge ? sra_pkg::RADIX_W'(trial - {1'b0, divisor})
                   : sra_pkg::RADIX_W'(trial);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(sra_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = q_r;
  assign res.rem  = rem_r;

endmodule

// File: rtl/core/sra_stack.sv
// ----------------------------------------------------------------------------
// sra_stack
// digit lifo as a shift line, top of stack at entry zero
// ----------------------------------------------------------------------------
module sra_stack #(
  parameter int DEPTH = sra_pkg::MAX_DIGITS,
  parameter int W     = 4
) (
  input  logic         clk,
  input  logic         push,
  input  logic         pop,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] stk_r   [DEPTH];
  logic [W-1:0] stk_nxt [DEPTH];

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      stk_nxt[k] = stk_r[k];
      if (push) begin
        stk_nxt[k] = (k == 0) ? din : stk_r[(k == 0) ? 0 : k - 1];
      end else if (pop && (k < DEPTH - 1)) begin
        stk_nxt[k] = stk_r[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    stk_r <= stk_nxt;
  end

  assign dout = stk_r[0];

endmodule
